/* rtl/slbs_pkg.sv */
// Shared types, constants and helper functions of the status LED blink sequencer.
package slbs_pkg;

    localparam int NUM_CLASSES = 6;

    localparam int LEVEL_W = 9;
    localparam int TICK_W  = 10;
    localparam int PAIRS_W = 4;
    localparam int LEFT_W  = 5;
    localparam int CLASS_W = 3;
    localparam int INDEX_W = 3;
    localparam int DATA_W  = 10;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 9'd256;
    localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 3'd7;
    localparam logic [CLASS_W:0]   NUM_CLASSES_W = 4'(NUM_CLASSES);

    localparam logic [TICK_W-1:0]  BLINK_ON_RST  = 10'd100;
    localparam logic [TICK_W-1:0]  BLINK_OFF_RST = 10'd200;
    localparam logic [TICK_W-1:0]  PULSE_RST     = 10'd80;
    localparam logic [PAIRS_W-1:0] PAIRS_RST     = 4'd3;
    localparam logic [LEVEL_W-1:0] ACTIVITY_RST  = 9'd90;
    localparam logic [LEVEL_W-1:0] LINKED_RST    = 9'd64;
    localparam logic [LEVEL_W-1:0] GRAY_RST      = 9'd38;
    localparam int                 LED_RST_INT   = (38 * 90) / 256;
    localparam logic [LEVEL_W-1:0] LED_RST       = LEVEL_W'(LED_RST_INT);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_CLASS = 2'd1,
        OP_LINK  = 2'd2,
        OP_PULSE = 2'd3
    } t_op;

    typedef enum logic [INDEX_W-1:0] {
        REG_BLINK_ON  = 3'd0,
        REG_BLINK_OFF = 3'd1,
        REG_PULSE     = 3'd2,
        REG_PAIRS     = 3'd3,
        REG_ACTIVITY  = 3'd4,
        REG_LINKED    = 3'd5,
        REG_GRAY      = 3'd6
    } t_reg_index;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [TICK_W-1:0]  on_ticks;
        logic [TICK_W-1:0]  off_ticks;
        logic [TICK_W-1:0]  pulse_ticks;
        logic [PAIRS_W-1:0] pairs;
        logic [LEVEL_W-1:0] activity_k;
        logic [LEVEL_W-1:0] linked_k;
        logic [LEVEL_W-1:0] gray_sat;
        logic [LEVEL_W-1:0] gray_level;
    } t_cfg;

    typedef struct packed {
        t_rgb levels;
        logic blinking;
    } t_result;

    function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] v);
        sat_level = (v > LEVEL_FULL) ? LEVEL_FULL : v;
    endfunction

    function automatic logic [TICK_W-1:0] ticks_of(input logic [TICK_W-1:0] v);
        ticks_of = (v == '0) ? TICK_W'(1) : v;
    endfunction

    // Returns which of red, green and blue are lit for a class, red in bit 2.
    function automatic logic [2:0] class_mask(input logic [CLASS_W-1:0] cls);
        case (cls)
            3'd0:    class_mask = 3'b010;
            3'd1:    class_mask = 3'b011;
            3'd2:    class_mask = 3'b110;
            3'd3:    class_mask = 3'b001;
            3'd4:    class_mask = 3'b101;
            3'd5:    class_mask = 3'b100;
            default: class_mask = 3'b111;
        endcase
    endfunction

endpackage

/* rtl/slbs_cfg.sv */
// Configuration registers with saturated and precomputed derived values.
module slbs_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [slbs_pkg::INDEX_W-1:0] i_cfg_index,
    input  logic [slbs_pkg::DATA_W-1:0]  i_cfg_data,
    output slbs_pkg::t_cfg               o_cfg
);

    logic [slbs_pkg::TICK_W-1:0]    r_on_ticks;
    logic [slbs_pkg::TICK_W-1:0]    r_off_ticks;
    logic [slbs_pkg::TICK_W-1:0]    r_pulse_ticks;
    logic [slbs_pkg::PAIRS_W-1:0]   r_pairs;
    logic [slbs_pkg::LEVEL_W-1:0]   r_activity;
    logic [slbs_pkg::LEVEL_W-1:0]   r_linked;
    logic [slbs_pkg::LEVEL_W-1:0]   r_gray;
    logic [2*slbs_pkg::LEVEL_W-1:0] gray_product;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_ticks    <= slbs_pkg::BLINK_ON_RST;
            r_off_ticks   <= slbs_pkg::BLINK_OFF_RST;
            r_pulse_ticks <= slbs_pkg::PULSE_RST;
            r_pairs       <= slbs_pkg::PAIRS_RST;
            r_activity    <= slbs_pkg::ACTIVITY_RST;
            r_linked      <= slbs_pkg::LINKED_RST;
            r_gray        <= slbs_pkg::GRAY_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                slbs_pkg::REG_BLINK_ON:  r_on_ticks    <= i_cfg_data;
                slbs_pkg::REG_BLINK_OFF: r_off_ticks   <= i_cfg_data;
                slbs_pkg::REG_PULSE:     r_pulse_ticks <= i_cfg_data;
                slbs_pkg::REG_PAIRS:     r_pairs       <= i_cfg_data[slbs_pkg::PAIRS_W-1:0];
                slbs_pkg::REG_ACTIVITY:  r_activity    <= i_cfg_data[slbs_pkg::LEVEL_W-1:0];
                slbs_pkg::REG_LINKED:    r_linked      <= i_cfg_data[slbs_pkg::LEVEL_W-1:0];
                slbs_pkg::REG_GRAY:      r_gray        <= i_cfg_data[slbs_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign gray_product = slbs_pkg::sat_level(r_gray) * slbs_pkg::sat_level(r_activity);

    always_comb begin
        o_cfg.on_ticks    = slbs_pkg::ticks_of(r_on_ticks);
        o_cfg.off_ticks   = slbs_pkg::ticks_of(r_off_ticks);
        o_cfg.pulse_ticks = slbs_pkg::ticks_of(r_pulse_ticks);
        o_cfg.pairs       = r_pairs;
        o_cfg.activity_k  = slbs_pkg::sat_level(r_activity);
        o_cfg.linked_k    = slbs_pkg::sat_level(r_linked);
        o_cfg.gray_sat    = slbs_pkg::sat_level(r_gray);
        o_cfg.gray_level  = gray_product[16:8];
    end

endmodule

/* rtl/slbs_core.sv */
// Sequencer state and the single-pass next-state and LED level logic.
module slbs_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  slbs_pkg::t_op                i_op,
    input  logic [slbs_pkg::CLASS_W-1:0] i_class_label,
    input  logic                         i_connected,
    input  slbs_pkg::t_cfg               i_cfg,
    output slbs_pkg::t_result            o_result
);

    logic                          r_link_up;
    logic [slbs_pkg::CLASS_W-1:0]  r_class;
    logic                          r_blink_active;
    logic [slbs_pkg::LEFT_W-1:0]   r_blink_left;
    logic                          r_uses_link;
    logic [slbs_pkg::TICK_W-1:0]   r_blink_timer;
    logic                          r_pulse_active;
    logic [slbs_pkg::TICK_W-1:0]   r_pulse_timer;
    slbs_pkg::t_rgb                r_led;

    logic                          n_link_up;
    logic [slbs_pkg::CLASS_W-1:0]  n_class;
    logic                          n_blink_active;
    logic [slbs_pkg::LEFT_W-1:0]   n_blink_left;
    logic                          n_uses_link;
    logic [slbs_pkg::TICK_W-1:0]   n_blink_timer;
    logic                          n_pulse_active;
    logic [slbs_pkg::TICK_W-1:0]   n_pulse_timer;
    slbs_pkg::t_rgb                n_led;

    logic                          class_known;
    logic [2:0]                    mask;
    slbs_pkg::t_rgb                disp_rgb;
    slbs_pkg::t_rgb                pulse_rgb;
    slbs_pkg::t_rgb                on_rgb;
    logic                          step_uses;
    logic [slbs_pkg::LEFT_W-1:0]   step_left;
    logic [slbs_pkg::LEFT_W-1:0]   step_dec;
    logic                          do_step;

    always_comb begin
        n_link_up = r_link_up;
        n_class   = r_class;
        if (i_op == slbs_pkg::OP_CLASS) begin
            n_class = ({1'b0, i_class_label} >= slbs_pkg::NUM_CLASSES_W)
                      ? slbs_pkg::CLASS_UNKNOWN : i_class_label;
        end else if (i_op == slbs_pkg::OP_LINK) begin
            n_link_up = i_connected;
            if (!i_connected) begin
                n_class = slbs_pkg::CLASS_UNKNOWN;
            end
        end
    end

    assign class_known = {1'b0, n_class} < slbs_pkg::NUM_CLASSES_W;
    assign mask        = slbs_pkg::class_mask(n_class);

    always_comb begin
        if (!n_link_up) begin
            disp_rgb  = '{i_cfg.gray_level, i_cfg.gray_level, i_cfg.gray_level};
            pulse_rgb = '{i_cfg.gray_sat, i_cfg.gray_sat, i_cfg.gray_sat};
        end else if (class_known) begin
            disp_rgb.red    = mask[2] ? i_cfg.activity_k : '0;
            disp_rgb.green  = mask[1] ? i_cfg.activity_k : '0;
            disp_rgb.blue   = mask[0] ? i_cfg.activity_k : '0;
            pulse_rgb.red   = mask[2] ? slbs_pkg::LEVEL_FULL : '0;
            pulse_rgb.green = mask[1] ? slbs_pkg::LEVEL_FULL : '0;
            pulse_rgb.blue  = mask[0] ? slbs_pkg::LEVEL_FULL : '0;
        end else begin
            disp_rgb  = '{'0, '0, i_cfg.linked_k};
            pulse_rgb = '{'0, '0, slbs_pkg::LEVEL_FULL};
        end
    end

    assign step_uses = (i_op == slbs_pkg::OP_LINK) ? i_connected : r_uses_link;
    assign step_left = (i_op == slbs_pkg::OP_LINK) ? {i_cfg.pairs, 1'b0} : r_blink_left;
    assign step_dec  = step_left - slbs_pkg::LEFT_W'(1);
    assign on_rgb    = step_uses ? slbs_pkg::t_rgb'{'0, '0, i_cfg.linked_k}
                                 : slbs_pkg::t_rgb'{i_cfg.gray_level, i_cfg.gray_level,
                                                    i_cfg.gray_level};

    always_comb begin
        n_blink_active = r_blink_active;
        n_blink_left   = r_blink_left;
        n_uses_link    = r_uses_link;
        n_blink_timer  = r_blink_timer;
        n_pulse_active = r_pulse_active;
        n_pulse_timer  = r_pulse_timer;
        n_led          = r_led;
        do_step        = 1'b0;

        unique case (i_op)
            slbs_pkg::OP_TICK: begin
                if (r_blink_active) begin
                    if (r_blink_timer <= slbs_pkg::TICK_W'(1)) begin
                        n_blink_timer = '0;
                        do_step       = 1'b1;
                    end else begin
                        n_blink_timer = r_blink_timer - slbs_pkg::TICK_W'(1);
                    end
                end
            end
            slbs_pkg::OP_CLASS: begin
                if (!r_blink_active) begin
                    n_led = disp_rgb;
                end
            end
            slbs_pkg::OP_LINK: begin
                n_pulse_active = 1'b0;
                n_pulse_timer  = '0;
                n_uses_link    = i_connected;
                n_blink_active = 1'b1;
                n_blink_timer  = '0;
                do_step        = 1'b1;
            end
            slbs_pkg::OP_PULSE: begin
                if (!r_blink_active) begin
                    n_led          = pulse_rgb;
                    n_pulse_active = 1'b1;
                    n_pulse_timer  = i_cfg.pulse_ticks;
                end
            end
            default: ;
        endcase

        if (do_step) begin
            if (step_left == '0) begin
                n_blink_left   = '0;
                n_blink_active = 1'b0;
                n_led          = disp_rgb;
            end else if (!step_left[0]) begin
                n_led         = on_rgb;
                n_blink_left  = step_dec;
                n_blink_timer = i_cfg.on_ticks;
            end else begin
                n_led        = '0;
                n_blink_left = step_dec;
                if (step_dec != '0) begin
                    n_blink_timer = i_cfg.off_ticks;
                end else begin
                    n_blink_active = 1'b0;
                    n_led          = disp_rgb;
                end
            end
        end

        if (i_op == slbs_pkg::OP_TICK && r_pulse_active) begin
            if (r_pulse_timer <= slbs_pkg::TICK_W'(1)) begin
                n_pulse_timer  = '0;
                n_pulse_active = 1'b0;
                if (!n_blink_active) begin
                    n_led = disp_rgb;
                end
            end else begin
                n_pulse_timer = r_pulse_timer - slbs_pkg::TICK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_up      <= 1'b0;
            r_class        <= slbs_pkg::CLASS_UNKNOWN;
            r_blink_active <= 1'b0;
            r_blink_left   <= '0;
            r_uses_link    <= 1'b0;
            r_blink_timer  <= '0;
            r_pulse_active <= 1'b0;
            r_pulse_timer  <= '0;
            r_led          <= '{slbs_pkg::LED_RST, slbs_pkg::LED_RST, slbs_pkg::LED_RST};
        end else if (i_step) begin
            r_link_up      <= n_link_up;
            r_class        <= n_class;
            r_blink_active <= n_blink_active;
            r_blink_left   <= n_blink_left;
            r_uses_link    <= n_uses_link;
            r_blink_timer  <= n_blink_timer;
            r_pulse_active <= n_pulse_active;
            r_pulse_timer  <= n_pulse_timer;
            r_led          <= n_led;
        end
    end

    assign o_result.levels   = n_led;
    assign o_result.blinking = n_blink_active;

endmodule

/* rtl/status_led_blink_sequencer.sv */
// Top level of the RGB status LED blink sequencer: input and result registers.
//
// Channel   Direction  Handshake                 Word
// in        input      i_in_valid / o_in_stall   operation, class label, connected
// out       output     o_out_valid / i_out_stall red, green, blue levels, blinking
// cfg       input      i_cfg_wr_en               register index and data
//
// A word accepted into the input register is processed by the core and its result is
// written to the result register; one word is taken every cycle while the output is
// not stalled.
// The state update and level logic run in a single pass in the core stage.
// Reset is synchronous and active low; it resets the valid flags, core state and settings.
// A stall on the output holds the result register and then the input register.
module status_led_blink_sequencer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_operation,
    input  logic [slbs_pkg::CLASS_W-1:0] i_class_label,
    input  logic                         i_connected,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [slbs_pkg::LEVEL_W-1:0] o_red_level,
    output logic [slbs_pkg::LEVEL_W-1:0] o_green_level,
    output logic [slbs_pkg::LEVEL_W-1:0] o_blue_level,
    output logic                         o_blinking,
    input  logic                         i_cfg_wr_en,
    input  logic [slbs_pkg::INDEX_W-1:0] i_cfg_index,
    input  logic [slbs_pkg::DATA_W-1:0]  i_cfg_data
);

    logic                         r_in_valid;
    slbs_pkg::t_op                r_op;
    logic [slbs_pkg::CLASS_W-1:0] r_class_label;
    logic                         r_connected;
    logic                         r_out_valid;
    slbs_pkg::t_result            r_result;

    slbs_pkg::t_cfg               cfg;
    slbs_pkg::t_result            core_result;
    logic                         advance;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_op          <= slbs_pkg::t_op'(i_operation);
            r_class_label <= i_class_label;
            r_connected   <= i_connected;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= core_result;
        end
    end

    slbs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    slbs_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_op          (r_op),
        .i_class_label (r_class_label),
        .i_connected   (r_connected),
        .i_cfg         (cfg),
        .o_result      (core_result)
    );

    assign o_out_valid   = r_out_valid;
    assign o_red_level   = r_result.levels.red;
    assign o_green_level = r_result.levels.green;
    assign o_blue_level  = r_result.levels.blue;
    assign o_blinking    = r_result.blinking;

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("Input stalled without a blocked result.");

    a_advance_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("Processed word did not reach the output.");

    a_levels_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_red_level <= slbs_pkg::LEVEL_FULL
            && o_green_level <= slbs_pkg::LEVEL_FULL && o_blue_level <= slbs_pkg::LEVEL_FULL)
        else $error("LED level above full scale.");

    a_reset_clears_output: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && !r_in_valid)
        else $error("Pipeline not empty after reset.");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the status LED blink sequencer with its own level predictor.
`timescale 1ns / 1ps

module tb;
    import slbs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [INDEX_W-1:0] REG_SPARE = 3'd7;
    localparam logic [LEVEL_W-1:0] LVL_OFF = '0;

    // Predicts the LED levels for each accepted word and checks the result words in order.
    class led_level_scoreboard;
        logic [TICK_W-1:0]  on_ticks;
        logic [TICK_W-1:0]  off_ticks;
        logic [TICK_W-1:0]  pulse_len;
        logic [PAIRS_W-1:0] pairs;
        logic [LEVEL_W-1:0] activity_k;
        logic [LEVEL_W-1:0] linked_k;
        logic [LEVEL_W-1:0] gray;
        bit                 link_up;
        logic [CLASS_W-1:0] shown_class;
        bit                 blinking;
        logic [LEFT_W-1:0]  blinks_left;
        bit                 blink_blue;
        logic [TICK_W-1:0]  blink_timer;
        bit                 pulsing;
        logic [TICK_W-1:0]  pulse_timer;
        t_rgb               levels;
        t_result            pending_levels[$];
        int                 failures;

        function new();
            on_ticks = 10'd100;
            off_ticks = 10'd200;
            pulse_len = 10'd80;
            pairs = 4'd3;
            activity_k = 9'd90;
            linked_k = 9'd64;
            gray = 9'd38;
            link_up = 0;
            shown_class = CLASS_UNKNOWN;
            blinking = 0;
            blinks_left = '0;
            blink_blue = 0;
            blink_timer = '0;
            pulsing = 0;
            pulse_timer = '0;
            failures = 0;
            restore();
        endfunction

        function void write_reg(logic [INDEX_W-1:0] index, logic [DATA_W-1:0] data);
            case (index)
                REG_BLINK_ON:  on_ticks = data[TICK_W-1:0];
                REG_BLINK_OFF: off_ticks = data[TICK_W-1:0];
                REG_PULSE:     pulse_len = data[TICK_W-1:0];
                REG_PAIRS:     pairs = data[PAIRS_W-1:0];
                REG_ACTIVITY:  activity_k = data[LEVEL_W-1:0];
                REG_LINKED:    linked_k = data[LEVEL_W-1:0];
                REG_GRAY:      gray = data[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        function int clip(int v);
            return (v > 256) ? 256 : v;
        endfunction

        function logic [TICK_W-1:0] at_least_one(logic [TICK_W-1:0] v);
            return (v == '0) ? TICK_W'(1) : v;
        endfunction

        function void paint(int r, int g, int b, int bright);
            int k;
            k = clip(bright);
            levels.red = LEVEL_W'(clip(r) * k >> 8);
            levels.green = LEVEL_W'(clip(g) * k >> 8);
            levels.blue = LEVEL_W'(clip(b) * k >> 8);
        endfunction

        function t_rgb base_color();
            t_rgb c;
            if (!link_up) begin
                c = {gray, gray, gray};
            end else if (shown_class < NUM_CLASSES) begin
                case (shown_class)
                    3'd0:    c = {LVL_OFF, LEVEL_FULL, LVL_OFF};
                    3'd1:    c = {LVL_OFF, LEVEL_FULL, LEVEL_FULL};
                    3'd2:    c = {LEVEL_FULL, LEVEL_FULL, LVL_OFF};
                    3'd3:    c = {LVL_OFF, LVL_OFF, LEVEL_FULL};
                    3'd4:    c = {LEVEL_FULL, LVL_OFF, LEVEL_FULL};
                    3'd5:    c = {LEVEL_FULL, LVL_OFF, LVL_OFF};
                    default: c = {LEVEL_FULL, LEVEL_FULL, LEVEL_FULL};
                endcase
            end else begin
                c = {LVL_OFF, LVL_OFF, LEVEL_FULL};
            end
            return c;
        endfunction

        function void restore();
            int   bright;
            t_rgb c;
            bright = (link_up && shown_class >= NUM_CLASSES) ? linked_k : activity_k;
            c = base_color();
            paint(c.red, c.green, c.blue, bright);
        endfunction

        function void blink_step();
            if (blinks_left == '0) begin
                blinking = 0;
                restore();
                return;
            end
            if (!blinks_left[0]) begin
                if (blink_blue) begin
                    paint(0, 0, 256, linked_k);
                end else begin
                    paint(gray, gray, gray, activity_k);
                end
                blinks_left--;
                blink_timer = at_least_one(on_ticks);
                return;
            end
            levels = '0;
            blinks_left--;
            if (blinks_left != '0) begin
                blink_timer = at_least_one(off_ticks);
                return;
            end
            blinking = 0;
            restore();
        endfunction

        function void note_word(t_op op, logic [CLASS_W-1:0] label, logic conn);
            t_rgb c;
            case (op)
                OP_TICK: begin
                    if (blinking) begin
                        if (blink_timer <= 1) begin
                            blink_timer = '0;
                            blink_step();
                        end else begin
                            blink_timer--;
                        end
                    end
                    if (pulsing) begin
                        if (pulse_timer <= 1) begin
                            pulse_timer = '0;
                            pulsing = 0;
                            if (!blinking) restore();
                        end else begin
                            pulse_timer--;
                        end
                    end
                end
                OP_CLASS: begin
                    shown_class = (label >= NUM_CLASSES) ? CLASS_UNKNOWN : label;
                    if (!blinking) restore();
                end
                OP_LINK: begin
                    link_up = conn;
                    if (!conn) shown_class = CLASS_UNKNOWN;
                    pulsing = 0;
                    pulse_timer = '0;
                    blink_blue = conn;
                    blinking = 1;
                    blinks_left = {pairs, 1'b0};
                    blink_timer = '0;
                    blink_step();
                end
                default: begin
                    if (!blinking) begin
                        c = base_color();
                        paint(c.red, c.green, c.blue, 256);
                        pulsing = 1;
                        pulse_timer = at_least_one(pulse_len);
                    end
                end
            endcase
            pending_levels.push_back({levels, blinking});
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (pending_levels.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result word: r %0d g %0d b %0d blinking %0b",
                             got.levels.red, got.levels.green, got.levels.blue, got.blinking);
                return;
            end
            want = pending_levels.pop_front();
            if (got.levels.red !== want.levels.red || got.levels.green !== want.levels.green ||
                    got.levels.blue !== want.levels.blue || got.blinking !== want.blinking) begin
                failures++;
                if (failures <= 10)
                    $display("level mismatch: expected r %0d g %0d b %0d blinking %0b, %s",
                             want.levels.red, want.levels.green, want.levels.blue,
                             want.blinking,
                             $sformatf("got r %0d g %0d b %0d blinking %0b",
                                       got.levels.red, got.levels.green, got.levels.blue,
                                       got.blinking));
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [1:0]           i_operation;
    logic [CLASS_W-1:0]   i_class_label;
    logic                 i_connected;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [LEVEL_W-1:0]   o_red_level;
    logic [LEVEL_W-1:0]   o_green_level;
    logic [LEVEL_W-1:0]   o_blue_level;
    logic                 o_blinking;
    logic                 i_cfg_wr_en;
    logic [INDEX_W-1:0]   i_cfg_index;
    logic [DATA_W-1:0]    i_cfg_data;

    led_level_scoreboard sb;
    int                  words_sent = 0;
    int                  cycle_count = 0;

    status_led_blink_sequencer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_class_label (i_class_label),
        .i_connected   (i_connected),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_red_level   (o_red_level),
        .o_green_level (o_green_level),
        .o_blue_level  (o_blue_level),
        .o_blinking    (o_blinking),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_word(t_op op, logic [CLASS_W-1:0] label, logic conn);
        int gap;
        gap = ((words_sent / 32) % 3 == 0) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_class_label <= label;
        i_connected <= conn;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(op, label, conn);
        words_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_levels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_settings(logic [DATA_W-1:0] on_t, logic [DATA_W-1:0] off_t,
                                 logic [DATA_W-1:0] pulse_t, logic [DATA_W-1:0] pairs_v,
                                 logic [DATA_W-1:0] act, logic [DATA_W-1:0] lnk,
                                 logic [DATA_W-1:0] gray_v);
        logic [DATA_W-1:0] vals [8];
        vals[REG_BLINK_ON] = on_t;
        vals[REG_BLINK_OFF] = off_t;
        vals[REG_PULSE] = pulse_t;
        vals[REG_PAIRS] = pairs_v;
        vals[REG_ACTIVITY] = act;
        vals[REG_LINKED] = lnk;
        vals[REG_GRAY] = gray_v;
        vals[REG_SPARE] = DATA_W'($urandom);
        for (int i = 0; i < 8; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= INDEX_W'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            sb.write_reg(INDEX_W'(i), vals[i]);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin : result_sink
        int      hold;
        int      taken;
        t_result got;
        taken = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = ((taken / 40) % 2 == 0) ? $urandom_range(0, 12) : 0;
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            got = {o_red_level, o_green_level, o_blue_level, o_blinking};
            sb.check_word(got);
            taken++;
        end
    end

    initial begin
        int  pick;
        t_op op;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_operation <= OP_TICK;
        i_class_label <= '0;
        i_connected <= 1'b0;
        i_out_stall <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= REG_BLINK_ON;
        i_cfg_data <= '0;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: pulse while disconnected, class change during the pulse,
        // link change cancelling it, pulse and class change during the blinks.
        send_word(OP_TICK, 3'd0, 1'b0);
        send_word(OP_PULSE, 3'd0, 1'b0);
        send_word(OP_CLASS, 3'd3, 1'b0);
        send_word(OP_LINK, 3'd0, 1'b1);
        send_word(OP_PULSE, 3'd0, 1'b0);
        send_word(OP_CLASS, CLASS_UNKNOWN, 1'b0);
        send_word(OP_LINK, 3'd0, 1'b0);
        drain();

        // Zero on time, saturated levels and a full notify sequence run to its end.
        load_settings(10'd0, 10'd1, 10'd2, 10'd2, 10'd300, 10'd256, 10'h3FF);
        send_word(OP_LINK, 3'd0, 1'b1);
        repeat (4) send_word(OP_TICK, 3'd0, 1'b0);
        send_word(OP_CLASS, 3'd6, 1'b0);
        send_word(OP_CLASS, 3'd2, 1'b0);
        send_word(OP_PULSE, 3'd0, 1'b0);
        send_word(OP_CLASS, 3'd5, 1'b0);
        send_word(OP_TICK, 3'd0, 1'b0);
        send_word(OP_TICK, 3'd0, 1'b0);
        send_word(OP_PULSE, 3'd0, 1'b0);
        send_word(OP_LINK, 3'd0, 1'b0);
        drain();

        // Zero blink pairs: the sequence ends in the step that starts it.
        load_settings(10'd1, 10'd1, 10'd1, 10'd0, 10'd256, 10'd0, 10'd256);
        send_word(OP_LINK, 3'd0, 1'b1);
        send_word(OP_PULSE, 3'd0, 1'b0);
        send_word(OP_TICK, 3'd0, 1'b0);
        send_word(OP_LINK, 3'd0, 1'b0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                1: load_settings(10'h3FF, 10'h3FF, 10'h3FF, 10'hF, 10'd0, 10'h3FF, 10'd256);
                2: load_settings(10'd1, 10'd1, 10'd1, 10'hF, 10'd256, 10'd0, 10'd256);
                3: load_settings(DATA_W'($urandom_range(1, 20)), DATA_W'($urandom_range(1, 20)),
                                 DATA_W'($urandom_range(1, 20)), DATA_W'($urandom_range(0, 15)),
                                 DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
                default: load_settings(DATA_W'($urandom_range(0, 4)),
                                       DATA_W'($urandom_range(0, 4)),
                                       DATA_W'($urandom_range(0, 6)),
                                       DATA_W'($urandom_range(0, 4)),
                                       DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
            endcase
            repeat (85) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) op = OP_TICK;
                else if (pick < 70) op = OP_CLASS;
                else if (pick < 82) op = OP_LINK;
                else op = OP_PULSE;
                send_word(op, CLASS_W'($urandom), 1'($urandom));
            end
            drain();
        end

        if (sb.failures == 0 && sb.pending_levels.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
